[src/fixed_partition_fit_allocator_assert.svh]
// Assertion macros for the fixed-partition fit allocator.
// Needs nothing else; included by fixed_partition_fit_allocator, which carries the assertions.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FPFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpfa assertion failed");

// Next-cycle implication, disabled during reset.
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpfa assertion failed");

`endif

[src/fpfa_pkg.sv]
// Shared types and constants of the fixed-partition fit allocator.
// No dependencies; used by fpfa_cell and fixed_partition_fit_allocator.
package fpfa_pkg;

  localparam int SIZE_W       = 16;
  localparam int NUMBER_W     = 4;
  localparam int WASTE_W      = 20;
  localparam int WASTE_SUM_W  = 21;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // fit policy codes; the spare code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = 5'd16;

  localparam logic [WASTE_SUM_W-1:0] WASTE_SUM_MAX = 21'h1FFFFF;
  localparam logic [WASTE_W-1:0]     WASTE_OUT_MAX = 20'hFFFFF;

  typedef struct packed {
    cmd_t              cmd;
    logic [SIZE_W-1:0] size;
  } request_t;

  typedef struct packed {
    logic                granted;
    logic [NUMBER_W-1:0] block_number;
    logic [WASTE_W-1:0]  waste_total;
  } result_t;

  // per-cell control from the top level
  typedef struct packed {
    logic       active;
    logic       clear;
    logic       write;
    logic       mark;
    logic [1:0] policy;
  } cell_ctl_t;

endpackage

[src/fpfa_cell.sv]
// One partition cell: holds a size and a used bit, and updates the scan token.
// Depends on fpfa_pkg.
module fpfa_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int SUM_W     = 21,
  parameter int INDEX     = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fpfa_pkg::cell_ctl_t                 ctl,
  input  logic [SIZE_BITS-1:0]                wr_size,
  input  logic [2*SIZE_BITS+IDX_W+SUM_W+1:0]  scan_in,
  output logic [2*SIZE_BITS+IDX_W+SUM_W+1:0]  scan_out
);
  import fpfa_pkg::*;

  typedef struct packed {
    logic                 valid;
    logic [SIZE_BITS-1:0] req;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
    logic [SUM_W-1:0]     free_sum;
  } token_t;

  logic [SIZE_BITS-1:0] size_q;
  logic                 used;
  token_t               tok_in;
  token_t               tok_next;
  token_t               tok_q;
  logic [SIZE_BITS-1:0] left;
  logic                 fits;

  assign tok_in   = scan_in;
  assign scan_out = tok_q;

  always_comb begin
    fits     = !used && (size_q > tok_in.req);
    left     = size_q - tok_in.req;
    tok_next = tok_in;
    if (tok_in.valid && ctl.active) begin
      if (!used) begin
        tok_next.free_sum = tok_in.free_sum + SUM_W'(size_q);
      end
      // first hit always taken; later hits only replace under best/worst fit
      if (fits && (!tok_in.found ||
                   (ctl.policy == FIT_BEST  && left < tok_in.best) ||
                   (ctl.policy == FIT_WORST && left > tok_in.best))) begin
        tok_next.found = 1'b1;
        tok_next.pick  = IDX_W'(INDEX);
        tok_next.best  = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_q      <= '0;
      used        <= 1'b0;
      tok_q.valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        size_q <= '0;
        used   <= 1'b0;
      end else if (ctl.write) begin
        size_q <= wr_size;
        used   <= 1'b0;
      end else if (ctl.mark) begin
        used <= 1'b1;
      end
      tok_q <= tok_next;
    end
  end

endmodule

[src/fixed_partition_fit_allocator.sv]
// Top level of the fixed-partition fit allocator: control, chain of cells, result.
// Depends on fpfa_pkg, fpfa_cell and fixed_partition_fit_allocator_assert.svh.
//
// Usage
//   A request (cmd, size) is taken at a rising edge with start high and busy low.
//   Load fills the next partition, allocate places a request into a free
//   partition strictly larger than it, report reads the waste, clear empties.
//   Each request gives one result, shown for exactly one cycle with done high.
//   The receiver cannot hold results off, so nothing here waits on it.
// Scan
//   The request walks a scan token from the head register down a row of
//   MAX_BLOCKS cells, one cell a cycle; done is registered from the tail.
//   The next request may start in the done cycle; busy holds requests off
//   until then, so the row carries one request at a time.
// Configuration
//   cfg_we/cfg_index/cfg_data write fit_policy (index 0) and block_count
//   (index 1); write only while idle. Other indices are ignored.
// Reset
//   Synchronous rst empties the table, zeroes the load pointer and waste sum,
//   sets first fit and a count of 16; the block is ready the cycle after.
module fixed_partition_fit_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  fpfa_pkg::request_t                    req,
  output logic                                  busy,
  output logic                                  done,
  output fpfa_pkg::result_t                     result,
  input  logic                                  cfg_we,
  input  logic [fpfa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import fpfa_pkg::*;
  `include "fixed_partition_fit_allocator_assert.svh"

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W  = SIZE_BITS + CNT_W;
  localparam int WS_W   = ((SIZE_BITS > WASTE_SUM_W) ? SIZE_BITS : WASTE_SUM_W) + 1;
  localparam int TOT_W  = ((SUM_W > WASTE_SUM_W) ? SUM_W : WASTE_SUM_W) + 2;
  localparam int TOK_W  = 2 * SIZE_BITS + IDX_W + SUM_W + 2;

  // scan token, same layout as inside the cells
  typedef struct packed {
    logic                 valid;
    logic [SIZE_BITS-1:0] req;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
    logic [SUM_W-1:0]     free_sum;
  } token_t;

  // configuration
  logic [1:0]            fit_policy;
  logic [CFG_DATA_W-1:0] block_count;

  // table bookkeeping
  logic [CNT_W-1:0]       load_pointer;
  logic [WASTE_SUM_W-1:0] waste_sum;

  // request in flight
  cmd_t                op_cmd;
  logic                op_granted;
  logic [NUMBER_W-1:0] op_number;
  token_t              head;
  token_t              head_next;

  logic             accept;
  logic [CNT_W-1:0] n_eff;
  logic             load_ok;
  logic [SIZE_BITS-1:0] req_size;

  logic [TOK_W-1:0] links [MAX_BLOCKS+1];
  cell_ctl_t        ctl   [MAX_BLOCKS];
  token_t           tail;

  // final arithmetic
  logic                   hit;
  logic [WS_W-1:0]        ws_ext;
  logic [WASTE_SUM_W-1:0] waste_sum_next;
  logic [TOT_W-1:0]       total;
  result_t                result_next;

  assign accept   = start && !busy;
  assign req_size = SIZE_BITS'(req.size);

  // effective count: block_count saturated at the table depth
  always_comb begin
    if (int'(block_count) > MAX_BLOCKS) begin
      n_eff = CNT_W'(MAX_BLOCKS);
    end else begin
      n_eff = CNT_W'(block_count);
    end
  end

  assign load_ok = (load_pointer < n_eff);

  // token injected at the head of the row; valid only on an accepted request
  always_comb begin
    head_next       = '0;
    head_next.valid = accept;
    head_next.req   = req_size;
  end

  // row of cells; token enters from head and leaves at tail
  assign links[0] = head;
  assign tail     = links[MAX_BLOCKS];

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign ctl[i].active = (CNT_W'(i) < n_eff);
    assign ctl[i].clear  = accept && (req.cmd == CMD_CLEAR);
    assign ctl[i].write  = accept && (req.cmd == CMD_LOAD) && load_ok &&
                           (load_pointer == CNT_W'(i));
    // the chosen partition is marked as the token leaves the row
    assign ctl[i].mark   = tail.valid && (op_cmd == CMD_ALLOC) && tail.found &&
                           (tail.pick == IDX_W'(i));
    assign ctl[i].policy = fit_policy;

    fpfa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .SUM_W     (SUM_W),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .wr_size  (req_size),
      .scan_in  (links[i]),
      .scan_out (links[i+1])
    );
  end

  // result: leftover of the pick joins the waste sum, its whole size leaves
  // the free total that the row gathered
  always_comb begin
    hit    = (op_cmd == CMD_ALLOC) && tail.found;
    ws_ext = WS_W'(waste_sum) + (hit ? WS_W'(tail.best) : WS_W'(0));
    if (ws_ext > WS_W'(WASTE_SUM_MAX)) begin
      waste_sum_next = WASTE_SUM_MAX;
    end else begin
      waste_sum_next = WASTE_SUM_W'(ws_ext);
    end
    total = TOT_W'(waste_sum_next) + TOT_W'(tail.free_sum);
    if (hit) begin
      total = total - (TOT_W'(tail.best) + TOT_W'(tail.req));
    end

    result_next = '0;
    if (total > TOT_W'(WASTE_OUT_MAX)) begin
      result_next.waste_total = WASTE_OUT_MAX;
    end else begin
      result_next.waste_total = WASTE_W'(total);
    end
    if (op_cmd == CMD_ALLOC) begin
      result_next.granted      = tail.found;
      result_next.block_number = tail.found ? NUMBER_W'(32'(tail.pick)) : '0;
    end else begin
      result_next.granted      = op_granted;
      result_next.block_number = op_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy   <= FIT_FIRST;
      block_count  <= BLOCK_COUNT_RESET;
      load_pointer <= '0;
      waste_sum    <= '0;
      busy         <= 1'b0;
      done         <= 1'b0;
      head.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY:  fit_policy  <= cfg_data[1:0];
          CFG_BLOCK_COUNT: block_count <= cfg_data;
          default: ;
        endcase
      end

      head       <= head_next;
      done       <= tail.valid;

      if (accept) begin
        busy          <= 1'b1;
        op_cmd        <= req.cmd;
        op_granted    <= 1'b0;
        op_number     <= '0;
        case (req.cmd)
          CMD_LOAD: begin
            if (load_ok) begin
              op_granted   <= 1'b1;
              op_number    <= NUMBER_W'(32'(load_pointer));
              load_pointer <= load_pointer + CNT_W'(1);
            end
          end
          CMD_CLEAR: begin
            load_pointer <= '0;
            waste_sum    <= '0;
          end
          default: ;
        endcase
      end

      // token leaves the row: commit and present the result
      if (tail.valid) begin
        busy      <= 1'b0;
        result    <= result_next;
        waste_sum <= waste_sum_next;
      end
    end
  end

  `FPFA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `FPFA_ASSERT_NOW(a_tail_in_op, clk, rst, tail.valid, busy && !head.valid)
  `FPFA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `FPFA_ASSERT_NOW(a_number_zero, clk, rst, done && !result.granted,
                   result.block_number == '0)

endmodule

[tb/sv/fpfa_waste_checker.sv]
// Result checker for the fixed-partition fit allocator: keeps its own copy of the
// partition table, predicts each result and compares it field by field.
// Depends on fpfa_pkg only.
module fpfa_waste_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  fpfa_pkg::request_t               req,
  input  logic                             busy,
  input  logic                             done,
  input  fpfa_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [fpfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               pending,
  output int                               failures
);
  import fpfa_pkg::*;

  // shadow of the block's table and registers
  logic [SIZE_W-1:0]     part_size [TABLE_DEPTH];
  bit                    part_used [TABLE_DEPTH];
  int unsigned           load_ptr;
  longint unsigned       leftover_sum;
  logic [1:0]            policy_reg;
  logic [CFG_DATA_W-1:0] count_reg;

  result_t predicted_results[$];
  int      errors_seen = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors_seen++;
  endtask

  task automatic wipe_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      part_size[i] = '0;
      part_used[i] = 1'b0;
    end
    load_ptr     = 0;
    leftover_sum = 0;
  endtask

  // one request against the shadow table; updates it and gives the result
  task automatic apply_command(input request_t r, output result_t res);
    int unsigned     active;
    int unsigned     pick;
    int unsigned     best_left;
    int unsigned     left;
    bit              found;
    longint unsigned total;
    res       = '0;
    active    = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
    found     = 1'b0;
    pick      = 0;
    best_left = 0;
    case (r.cmd)
      CMD_LOAD: begin
        if (load_ptr < active) begin
          part_size[load_ptr] = r.size;
          part_used[load_ptr] = 1'b0;
          res.granted         = 1'b1;
          res.block_number    = NUMBER_W'(load_ptr);
          load_ptr++;
        end
      end
      CMD_ALLOC: begin
        for (int i = 0; i < active; i++) begin
          if (!part_used[i] && part_size[i] > r.size) begin
            left = part_size[i] - r.size;
            if (!found) begin
              found     = 1'b1;
              pick      = i;
              best_left = left;
            end else if (policy_reg == FIT_BEST && left < best_left) begin
              pick      = i;
              best_left = left;
            end else if (policy_reg == FIT_WORST && left > best_left) begin
              pick      = i;
              best_left = left;
            end
          end
        end
        if (found) begin
          part_used[pick] = 1'b1;
          leftover_sum    = leftover_sum + best_left;
          if (leftover_sum > WASTE_SUM_MAX)
            leftover_sum = WASTE_SUM_MAX;
          res.granted      = 1'b1;
          res.block_number = NUMBER_W'(pick);
        end
      end
      CMD_CLEAR: wipe_table();
      default: ;
    endcase
    total = leftover_sum;
    for (int i = 0; i < active; i++)
      if (!part_used[i])
        total += part_size[i];
    res.waste_total = (total > WASTE_OUT_MAX) ? WASTE_OUT_MAX : WASTE_W'(total);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      wipe_table();
      policy_reg = FIT_FIRST;
      count_reg  = BLOCK_COUNT_RESET;
      predicted_results.delete();
    end else begin
      // compare before pushing: a request may be taken in the done cycle
      if (done) begin
        if (predicted_results.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = predicted_results.pop_front();
          if (result.granted !== want.granted)
            flag_mismatch($sformatf("granted %b, expected %b",
                                    result.granted, want.granted));
          if (result.block_number !== want.block_number)
            flag_mismatch($sformatf("block_number %0d, expected %0d",
                                    result.block_number, want.block_number));
          if (result.waste_total !== want.waste_total)
            flag_mismatch($sformatf("waste_total %0d, expected %0d",
                                    result.waste_total, want.waste_total));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY:  policy_reg = cfg_data[1:0];
          CFG_BLOCK_COUNT: count_reg  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        apply_command(req, want);
        predicted_results.push_back(want);
      end
    end
    pending  <= predicted_results.size();
    failures <= errors_seen;
  end

endmodule

[tb/sv/fixed_partition_fit_allocator_tb.sv]
// Testbench top for the fixed-partition fit allocator: clock, reset, requests,
// register writes and the verdict. Depends on fpfa_pkg, the allocator and
// fpfa_waste_checker, which does all prediction and comparison.
module fixed_partition_fit_allocator_tb;
  import fpfa_pkg::*;

  localparam int MAX_BLOCKS = 16;
  localparam int ITEM_GOAL  = 1450;

  // codes the package leaves unnamed
  localparam logic [1:0]             FIT_SPARE       = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  request_t               req       = '0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   busy;
  logic                   done;
  result_t                result;
  int                     pending;
  int                     failures;

  int items_sent   = 0;
  int reg_writes   = 0;
  int idle_pct     = 0;   // chance, in percent, of a gap before a request

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_partition_fit_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_BITS (SIZE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fpfa_waste_checker #(
    .TABLE_DEPTH(MAX_BLOCKS)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pending  (pending),
    .failures (failures)
  );

  // Issue one request. An optional gap with start low lets
  // the next request land on any phase of the scan. Without a gap start
  // stays high across back-to-back requests (one NBA per step). Returns just
  // after the edge that took the request.
  task automatic send_request(input cmd_t c, input logic [SIZE_W-1:0] s);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{cmd: c, size: s};
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Register write while idle. The first edge lets the checker's outstanding
  // count take in the request just accepted; then wait for it to drain.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // Partition sizes: extremes, full range, small values that make fits likely
  // and a few multiples of 64 so that best/worst fit ties turn up.
  function automatic logic [SIZE_W-1:0] pick_partition_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom_range(65535));
      4, 5:    return SIZE_W'($urandom_range(1, 4) * 64);
      default: return SIZE_W'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_request_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(65535));
      3:       return SIZE_W'($urandom_range(0, 4) * 64);
      default: return SIZE_W'($urandom_range(0, 400));
    endcase
  endfunction

  // Block counts lean on the extremes: none, one, exactly full, saturated.
  function automatic logic [CFG_DATA_W-1:0] pick_block_count();
    case ($urandom_range(5))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      default: return CFG_DATA_W'($urandom_range(31));
    endcase
  endfunction

  // Hand-picked opening: reset state, full table, no fit, exact-size request,
  // ties under best fit, worst fit, the spare policy, a zero count and writes
  // to unmapped register indexes.
  task automatic directed_requests();
    send_request(CMD_REPORT, 16'h0000);
    send_request(CMD_ALLOC,  16'h0000);   // empty table: nothing fits
    send_request(CMD_LOAD,   16'd7);
    send_request(CMD_CLEAR,  16'hFFFF);

    write_register(CFG_BLOCK_COUNT, 5'd3);
    write_register(CFG_FIT_POLICY,  CFG_DATA_W'(FIT_FIRST));
    send_request(CMD_LOAD,  16'd0);
    send_request(CMD_LOAD,  16'hFFFF);
    send_request(CMD_LOAD,  16'd100);
    send_request(CMD_LOAD,  16'd5);       // table full
    send_request(CMD_ALLOC, 16'hFFFF);    // equal size is not a fit
    send_request(CMD_ALLOC, 16'd0);       // size-0 partition skipped
    send_request(CMD_ALLOC, 16'd99);      // leftover of one
    send_request(CMD_ALLOC, 16'd0);       // no free partition fits
    send_request(CMD_REPORT, 16'h5A5A);
    send_request(CMD_CLEAR,  16'h0000);

    write_register(CFG_BLOCK_COUNT, 5'd31);   // saturates to the full table
    write_register(CFG_FIT_POLICY,  CFG_DATA_W'(FIT_BEST));
    send_request(CMD_LOAD,  16'd50);
    send_request(CMD_LOAD,  16'd20);
    send_request(CMD_LOAD,  16'd30);
    send_request(CMD_LOAD,  16'd20);
    send_request(CMD_LOAD,  16'd80);
    send_request(CMD_ALLOC, 16'd15);      // tie: lower index wins
    send_request(CMD_ALLOC, 16'd15);
    write_register(CFG_FIT_POLICY, CFG_DATA_W'(FIT_WORST));
    send_request(CMD_ALLOC, 16'd15);
    write_register(CFG_FIT_POLICY, CFG_DATA_W'(FIT_SPARE));
    send_request(CMD_ALLOC, 16'd15);      // spare code acts as first fit

    write_register(CFG_BLOCK_COUNT, 5'd0);
    send_request(CMD_LOAD,   16'd9);
    send_request(CMD_REPORT, 16'h0000);
    write_register(CFG_UNMAPPED_LO, 5'h1F);
    write_register(CFG_UNMAPPED_HI, 5'h00);
    write_register(CFG_BLOCK_COUNT, BLOCK_COUNT_RESET);
    send_request(CMD_REPORT, 16'h0000);
  endtask

  // Random traffic up to a running item total. Mostly clear/load/allocate runs
  // so the table really fills; the rest is new settings and loose requests.
  task automatic random_requests(input int item_target);
    int roll;
    while (items_sent < item_target) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        write_register(CFG_FIT_POLICY,  CFG_DATA_W'($urandom_range(3)));
        write_register(CFG_BLOCK_COUNT, pick_block_count());
        if ($urandom_range(7) == 0)
          write_register(($urandom_range(1) == 0) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                         CFG_DATA_W'($urandom_range(31)));
      end else if (roll < 82) begin
        if ($urandom_range(4) != 0)
          send_request(CMD_CLEAR, SIZE_W'($urandom_range(65535)));
        repeat ($urandom_range(1, MAX_BLOCKS + 1))
          send_request(CMD_LOAD, pick_partition_size());
        repeat ($urandom_range(1, 12))
          send_request(CMD_ALLOC, pick_request_size());
        if ($urandom_range(2) == 0)
          send_request(CMD_REPORT, SIZE_W'($urandom_range(65535)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(cmd_t'($urandom_range(3)), SIZE_W'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    int idle_levels [4];
    int directed_count;
    int spins;
    int total_failures;
    idle_levels = '{0, 64, 15, 0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_requests();
    directed_count = items_sent;

    // four stretches: no gaps, heavy gaps, light gaps, no gaps again
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_levels[p];
      random_requests(directed_count + (ITEM_GOAL - directed_count) * (p + 1) / 4);
    end

    // drain, then keep clocking idle so that anything stray shows
    start <= 1'b0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while ((pending != 0 || busy) && spins < 1000);
    repeat (MAX_BLOCKS + 4) @(posedge clk);

    total_failures = failures;
    if (pending != 0) begin
      $display("ERROR: %0d predicted results never arrived", pending);
      total_failures += pending;
    end

    $display("Ran %0d requests (%0d hand-picked) and %0d register writes,", items_sent,
             directed_count, reg_writes);
    $display("all fit policies, block counts 0 to 31, sender gaps of 0/15/64 percent.");
    if (total_failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop well beyond the slowest legitimate run
  initial begin
    #4000000;
    $display("ERROR: run timed out");
    $display("Test completed with failures");
    $finish;
  end

endmodule

[fixed_partition_fit_allocator.f]
+incdir+src
src/fpfa_pkg.sv
src/fpfa_cell.sv
src/fixed_partition_fit_allocator.sv
tb/sv/fpfa_waste_checker.sv
tb/sv/fixed_partition_fit_allocator_tb.sv
